>>> design/psch_pkg.sv
// shared types, widths and codes for the periodic priority task scheduler
// no dependencies; every other design file refers to this package by scoped name
package psch_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  localparam int FUNC_W     = 3;
  localparam int PERIOD_W   = 32;
  localparam int PRIO_W     = 8;
  localparam int TICK_W     = 32;
  localparam int FIELD_IDX_W = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PICK     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_YIELD    = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INT_TASK   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SCHED_TASK = 2'd2;

  localparam logic [TICK_W-1:0]      INTERVAL_RESET   = 32'd10000;
  localparam logic [FIELD_IDX_W-1:0] INT_TASK_RESET   = 4'd1;
  localparam logic [FIELD_IDX_W-1:0] SCHED_TASK_RESET = 4'd0;

  typedef enum logic [1:0] {
    ST_BLOCKED = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } status_t;

  // request broadcast to every cell for the length of one sweep
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [PERIOD_W-1:0] period;
    logic [PRIO_W-1:0]   prio;
    logic [TICK_W-1:0]   tick;
    logic [CNT_W-1:0]    count;
    logic                add_v;
    logic                done_v;
    logic [IDX_W-1:0]    done_idx;
    logic                launch_v;
    logic [IDX_W-1:0]    int_idx;
    logic                cur_v;
    logic [IDX_W-1:0]    cur_idx;
    logic                sched_v;
    logic [IDX_W-1:0]    sched_idx;
  } cmd_t;

  // running result handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [IDX_W-1:0]  idx;
    logic              launched;
  } carry_t;

  // marks the pick winner running once the sweep is over
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } commit_t;

  function automatic logic in_table(input logic [FIELD_IDX_W-1:0] f,
                                    input logic [CNT_W-1:0] n);
    return 32'(f) < 32'(n);
  endfunction

  function automatic logic [IDX_W-1:0] to_slot(input logic [FIELD_IDX_W-1:0] f);
    logic [31:0] w;
    w = 32'(f);
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [FIELD_IDX_W-1:0] to_field(input logic [IDX_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[FIELD_IDX_W-1:0];
  endfunction

endpackage

>>> design/psch_if.sv
// request and response channel interfaces of the task scheduler
// depends on psch_pkg for field widths
interface psch_req_if;
  logic                             valid;
  logic                             ready;
  logic [psch_pkg::FUNC_W-1:0]      func;
  logic [psch_pkg::PERIOD_W-1:0]    period_in;
  logic [psch_pkg::PRIO_W-1:0]      priority_in;
  logic [psch_pkg::FIELD_IDX_W-1:0] index_in;

  modport source (output valid, func, period_in, priority_in, index_in, input ready);
  modport sink   (input valid, func, period_in, priority_in, index_in, output ready);
endinterface

interface psch_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             accepted;
  logic                             found;
  logic [psch_pkg::FIELD_IDX_W-1:0] chosen_index;
  logic                             interrupt_launched;
  logic [psch_pkg::FIELD_IDX_W-1:0] running_index;

  modport source (output valid, accepted, found, chosen_index, interrupt_launched,
                  running_index, input ready);
  modport sink   (input valid, accepted, found, chosen_index, interrupt_launched,
                  running_index, output ready);
endinterface

>>> design/psch_cell.sv
// one task table entry: period, priority, last-run stamp and status
// acts when the sweep token passes it and on a pick commit; depends on psch_pkg
module psch_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [psch_pkg::IDX_W-1:0]   cell_idx,
  input  psch_pkg::cmd_t               cmd,
  input  psch_pkg::commit_t            commit,
  input  logic                         tok_in,
  input  psch_pkg::carry_t             carry_in,
  output logic                         tok_out,
  output psch_pkg::carry_t             carry_out
);

  logic [psch_pkg::PERIOD_W-1:0] period;
  logic [psch_pkg::PRIO_W-1:0]   prio;
  logic [psch_pkg::TICK_W-1:0]   last_run;
  psch_pkg::status_t             status;

  psch_pkg::status_t             status_next;
  psch_pkg::status_t             status_rel;
  psch_pkg::carry_t              carry_next;
  logic                          load_entry;
  logic                          load_stamp;
  logic                          in_use;
  logic [psch_pkg::TICK_W-1:0]   elapsed;

  assign in_use  = 32'(cell_idx) < 32'(cmd.count);
  assign elapsed = cmd.tick - last_run;

  always_comb begin
    status_rel = status;
    if (in_use && period != '0 && status == psch_pkg::ST_BLOCKED && elapsed >= period) begin
      status_rel = psch_pkg::ST_READY;
    end
  end

  always_comb begin
    status_next = status;
    carry_next  = carry_in;
    load_entry  = 1'b0;
    load_stamp  = 1'b0;
    if (tok_in) begin
      case (cmd.func)
        psch_pkg::FUNC_ADD: begin
          if (cmd.add_v && cell_idx == cmd.count[psch_pkg::IDX_W-1:0]) begin
            load_entry  = 1'b1;
            status_next = psch_pkg::ST_BLOCKED;
          end
        end
        psch_pkg::FUNC_TICK: begin
          status_next = status_rel;
          // launch sees the status after this tick's release
          if (cmd.launch_v && cell_idx == cmd.int_idx &&
              status_rel == psch_pkg::ST_BLOCKED) begin
            status_next         = psch_pkg::ST_RUNNING;
            carry_next.launched = 1'b1;
          end
        end
        psch_pkg::FUNC_PICK: begin
          if (status == psch_pkg::ST_READY && (!carry_in.found || prio > carry_in.prio)) begin
            carry_next.found = 1'b1;
            carry_next.prio  = prio;
            carry_next.idx   = cell_idx;
          end
        end
        psch_pkg::FUNC_COMPLETE: begin
          if (cmd.done_v && cell_idx == cmd.done_idx) begin
            load_stamp  = 1'b1;
            status_next = psch_pkg::ST_BLOCKED;
          end
        end
        psch_pkg::FUNC_YIELD: begin
          if (cmd.sched_v && cell_idx == cmd.sched_idx) begin
            status_next = psch_pkg::ST_RUNNING;
          end else if (cmd.cur_v && cell_idx == cmd.cur_idx) begin
            status_next = psch_pkg::ST_BLOCKED;
          end
        end
        default: begin
        end
      endcase
    end
    if (commit.valid && commit.idx == cell_idx) begin
      status_next = psch_pkg::ST_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status  <= psch_pkg::ST_BLOCKED;
      tok_out <= 1'b0;
    end else begin
      status  <= status_next;
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load_entry) begin
      period <= cmd.period;
      prio   <= cmd.prio;
    end
    if (load_entry || load_stamp) begin
      last_run <= cmd.tick;
    end
    if (tok_in) begin
      carry_out <= carry_next;
    end
  end

endmodule

>>> design/psch_ctrl.sv
// request control: config registers, tick and interval counters, task count,
// current task, sweep launch and result register; depends on psch_pkg, psch_if
module psch_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  psch_req_if.sink                          req,
  psch_rsp_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [psch_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [psch_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              tok_ret,
  input  psch_pkg::carry_t                  carry_ret,
  output logic                              start,
  output psch_pkg::cmd_t                    cmd,
  output psch_pkg::commit_t                 commit
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_DONE  = 3'b100
  } state_t;

  state_t state;

  logic [psch_pkg::TICK_W-1:0]      interval_cfg;
  logic [psch_pkg::FIELD_IDX_W-1:0] int_task;
  logic [psch_pkg::FIELD_IDX_W-1:0] sched_task;

  logic [psch_pkg::CNT_W-1:0]       task_count;
  logic [psch_pkg::TICK_W-1:0]      tick_count;
  logic [psch_pkg::TICK_W-1:0]      interval_count;
  logic [psch_pkg::FIELD_IDX_W-1:0] current_task;

  logic                             accept;
  logic                             load;
  logic [psch_pkg::TICK_W-1:0]      tick_inc;
  logic [psch_pkg::TICK_W-1:0]      interval_inc;
  logic                             hit;
  logic                             is_tick;
  logic                             add_ok;
  psch_pkg::cmd_t                   cmd_next;

  logic                             is_pick_found;
  logic                             is_launch;
  logic [psch_pkg::FIELD_IDX_W-1:0] current_next;
  logic [psch_pkg::FIELD_IDX_W-1:0] chosen_next;

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign load         = (state == S_DONE) && (!rsp.valid || rsp.ready);

  assign tick_inc     = tick_count + 1'b1;
  assign interval_inc = interval_count + 1'b1;
  assign hit          = interval_inc >= interval_cfg;
  assign is_tick      = (req.func == psch_pkg::FUNC_TICK);
  assign add_ok       = (req.func == psch_pkg::FUNC_ADD) &&
                        (task_count < psch_pkg::CNT_W'(psch_pkg::TASK_SLOTS));

  always_comb begin
    cmd_next.func      = req.func;
    cmd_next.period    = req.period_in;
    cmd_next.prio      = req.priority_in;
    cmd_next.tick      = is_tick ? tick_inc : tick_count;
    cmd_next.count     = task_count;
    cmd_next.add_v     = add_ok;
    cmd_next.done_v    = psch_pkg::in_table(req.index_in, task_count);
    cmd_next.done_idx  = psch_pkg::to_slot(req.index_in);
    cmd_next.launch_v  = hit && psch_pkg::in_table(int_task, task_count);
    cmd_next.int_idx   = psch_pkg::to_slot(int_task);
    cmd_next.cur_v     = psch_pkg::in_table(current_task, task_count);
    cmd_next.cur_idx   = psch_pkg::to_slot(current_task);
    cmd_next.sched_v   = psch_pkg::in_table(sched_task, task_count);
    cmd_next.sched_idx = psch_pkg::to_slot(sched_task);
  end

  assign is_pick_found = (cmd.func == psch_pkg::FUNC_PICK) && carry_ret.found;
  assign is_launch     = (cmd.func == psch_pkg::FUNC_TICK) && carry_ret.launched;

  always_comb begin
    current_next = current_task;
    if (is_launch) begin
      current_next = int_task;
    end else if (cmd.func == psch_pkg::FUNC_YIELD) begin
      current_next = sched_task;
    end
    chosen_next = '0;
    if (cmd.add_v) begin
      chosen_next = psch_pkg::to_field(cmd.count[psch_pkg::IDX_W-1:0]);
    end else if (is_pick_found) begin
      chosen_next = psch_pkg::to_field(carry_ret.idx);
    end
  end

  assign commit.valid = load && is_pick_found;
  assign commit.idx   = carry_ret.idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_cfg <= psch_pkg::INTERVAL_RESET;
      int_task     <= psch_pkg::INT_TASK_RESET;
      sched_task   <= psch_pkg::SCHED_TASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psch_pkg::CFG_INTERVAL:   interval_cfg <= cfg_data;
        psch_pkg::CFG_INT_TASK:   int_task     <= cfg_data[psch_pkg::FIELD_IDX_W-1:0];
        psch_pkg::CFG_SCHED_TASK: sched_task   <= cfg_data[psch_pkg::FIELD_IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      start          <= 1'b0;
      task_count     <= '0;
      tick_count     <= '0;
      interval_count <= '0;
      current_task   <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      start <= accept;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SWEEP;
            if (is_tick) begin
              tick_count     <= tick_inc;
              interval_count <= hit ? '0 : interval_inc;
            end
            if (add_ok) begin
              task_count <= task_count + 1'b1;
            end
          end
        end
        S_SWEEP: begin
          if (tok_ret) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state        <= S_IDLE;
            current_task <= current_next;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
    if (load) begin
      rsp.accepted           <= cmd.add_v;
      rsp.found              <= is_pick_found;
      rsp.chosen_index       <= chosen_next;
      rsp.interrupt_launched <= is_launch;
      rsp.running_index      <= current_next;
    end
  end

  a_start_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> start)
    else $error("sweep not launched after request");

  a_token_in_sweep: assert property (@(posedge clk) disable iff (rst)
    tok_ret |-> state == S_SWEEP)
    else $error("token returned outside a sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    task_count <= psch_pkg::CNT_W'(psch_pkg::TASK_SLOTS))
    else $error("task count beyond table size");

  a_launch_runs: assert property (@(posedge clk) disable iff (rst)
    (load && is_launch) |=> (rsp.running_index == int_task && rsp.interrupt_launched))
    else $error("launched interrupt task is not the running task");

endmodule

>>> design/periodic_priority_task_scheduler_unit.sv
// top level of the periodic priority task scheduler: control block and a chain
// of task cells; depends on psch_pkg, psch_if, psch_cell, psch_ctrl
//
//  port        dir   handshake          carries
//  req         in    valid / ready      func, period_in, priority_in, index_in
//  rsp         out   valid / ready      accepted, found, chosen_index,
//                                       interrupt_launched, running_index
//  cfg_*       in    cfg_we only        cfg_index, cfg_data
//
// each request launches a token that walks the cell chain one cell per cycle;
// its return to control is followed by the result load
// one request is in the cell chain at a time; the next is taken once the
// result register is loaded, even while that result still waits on rsp.ready
// synchronous active-high reset: all tasks blocked, counters and count zero
// a stalled rsp holds the finished result and parks the next one in control
module periodic_priority_task_scheduler_unit (
  input  logic                            clk,
  input  logic                            rst,
  psch_req_if.sink                        req,
  psch_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [psch_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [psch_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              tok   [0:psch_pkg::TASK_SLOTS];
  psch_pkg::carry_t  carry [0:psch_pkg::TASK_SLOTS];
  psch_pkg::cmd_t    cmd;
  psch_pkg::commit_t commit;

  assign carry[0] = '0;

  psch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tok_ret   (tok[psch_pkg::TASK_SLOTS]),
    .carry_ret (carry[psch_pkg::TASK_SLOTS]),
    .start     (tok[0]),
    .cmd       (cmd),
    .commit    (commit)
  );

  for (genvar i = 0; i < psch_pkg::TASK_SLOTS; i++) begin : g_cell
    psch_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (psch_pkg::IDX_W'(i)),
      .cmd       (cmd),
      .commit    (commit),
      .tok_in    (tok[i]),
      .carry_in  (carry[i]),
      .tok_out   (tok[i+1]),
      .carry_out (carry[i+1])
    );
  end

endmodule

>>> bench/tb_top.sv
// self-checking bench for periodic_priority_task_scheduler_unit: directed and random requests
// uses psch_pkg and the psch_req_if / psch_rsp_if interfaces; a scoreboard class predicts rsp
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int PHASE_ITEMS     = 256;

  localparam logic [psch_pkg::FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [psch_pkg::FUNC_W-1:0] FUNC_UNUSED_MID   = 3'd6;
  localparam logic [psch_pkg::FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic                             accepted;
    logic                             found;
    logic [psch_pkg::FIELD_IDX_W-1:0] chosen_index;
    logic                             interrupt_launched;
    logic [psch_pkg::FIELD_IDX_W-1:0] running_index;
  } sched_rsp_t;

  class task_table_model;
    logic [psch_pkg::PERIOD_W-1:0]    period_tab [psch_pkg::TASK_SLOTS];
    logic [psch_pkg::PRIO_W-1:0]      prio_tab   [psch_pkg::TASK_SLOTS];
    logic [psch_pkg::TICK_W-1:0]      stamp_tab  [psch_pkg::TASK_SLOTS];
    psch_pkg::status_t                state_tab  [psch_pkg::TASK_SLOTS];
    int                               n_tasks;
    logic [psch_pkg::TICK_W-1:0]      ticks;
    logic [psch_pkg::TICK_W-1:0]      since_launch;
    logic [psch_pkg::TICK_W-1:0]      interval;
    logic [psch_pkg::FIELD_IDX_W-1:0] int_task;
    logic [psch_pkg::FIELD_IDX_W-1:0] sched_task;
    logic [psch_pkg::FIELD_IDX_W-1:0] current;
    sched_rsp_t                       expected_rsp [$];
    int                               errors;

    function new();
      for (int i = 0; i < psch_pkg::TASK_SLOTS; i++) begin
        period_tab[i] = '0;
        prio_tab[i]   = '0;
        stamp_tab[i]  = '0;
        state_tab[i]  = psch_pkg::ST_BLOCKED;
      end
      n_tasks      = 0;
      ticks        = '0;
      since_launch = '0;
      interval     = psch_pkg::INTERVAL_RESET;
      int_task     = psch_pkg::INT_TASK_RESET;
      sched_task   = psch_pkg::SCHED_TASK_RESET;
      current      = '0;
      errors       = 0;
    endfunction

    function void write_reg(input logic [psch_pkg::CFG_ADDR_W-1:0] idx,
                            input logic [psch_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        psch_pkg::CFG_INTERVAL:   interval   = data;
        psch_pkg::CFG_INT_TASK:   int_task   = data[psch_pkg::FIELD_IDX_W-1:0];
        psch_pkg::CFG_SCHED_TASK: sched_task = data[psch_pkg::FIELD_IDX_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(input logic [psch_pkg::FUNC_W-1:0] func,
                               input logic [psch_pkg::PERIOD_W-1:0] period,
                               input logic [psch_pkg::PRIO_W-1:0] prio,
                               input logic [psch_pkg::FIELD_IDX_W-1:0] idx);
      sched_rsp_t                  exp;
      logic [psch_pkg::TICK_W-1:0] elapsed;
      int                          best;
      exp = '0;
      case (func)
        psch_pkg::FUNC_ADD: begin
          if (n_tasks < psch_pkg::TASK_SLOTS) begin
            period_tab[n_tasks] = period;
            prio_tab[n_tasks]   = prio;
            stamp_tab[n_tasks]  = ticks;
            state_tab[n_tasks]  = psch_pkg::ST_BLOCKED;
            exp.accepted        = 1'b1;
            exp.chosen_index    = psch_pkg::FIELD_IDX_W'(n_tasks);
            n_tasks++;
          end
        end
        psch_pkg::FUNC_TICK: begin
          ticks = ticks + 1'b1;
          for (int i = 0; i < n_tasks; i++) begin
            elapsed = ticks - stamp_tab[i];
            if (period_tab[i] != '0 && state_tab[i] == psch_pkg::ST_BLOCKED &&
                elapsed >= period_tab[i])
              state_tab[i] = psch_pkg::ST_READY;
          end
          since_launch = since_launch + 1'b1;
          if (since_launch >= interval) begin
            since_launch = '0;
            if (int'(int_task) < n_tasks && state_tab[int_task] == psch_pkg::ST_BLOCKED) begin
              state_tab[int_task]    = psch_pkg::ST_RUNNING;
              current                = int_task;
              exp.interrupt_launched = 1'b1;
            end
          end
        end
        psch_pkg::FUNC_PICK: begin
          best = 0;
          for (int i = 0; i < n_tasks; i++) begin
            // strict compare keeps the lowest index on a priority tie
            if (state_tab[i] == psch_pkg::ST_READY &&
                (!exp.found || prio_tab[i] > prio_tab[best])) begin
              best      = i;
              exp.found = 1'b1;
            end
          end
          if (exp.found) begin
            state_tab[best]  = psch_pkg::ST_RUNNING;
            exp.chosen_index = psch_pkg::FIELD_IDX_W'(best);
          end
        end
        psch_pkg::FUNC_COMPLETE: begin
          if (int'(idx) < n_tasks) begin
            stamp_tab[idx] = ticks;
            state_tab[idx] = psch_pkg::ST_BLOCKED;
          end
        end
        psch_pkg::FUNC_YIELD: begin
          if (int'(current) < n_tasks) state_tab[current] = psch_pkg::ST_BLOCKED;
          current = sched_task;
          if (int'(current) < n_tasks) state_tab[current] = psch_pkg::ST_RUNNING;
        end
        default: ;
      endcase
      exp.running_index = current;
      expected_rsp.push_back(exp);
    endfunction

    function void check_response(input logic acc, input logic fnd,
                                 input logic [psch_pkg::FIELD_IDX_W-1:0] chosen,
                                 input logic irq,
                                 input logic [psch_pkg::FIELD_IDX_W-1:0] running);
      sched_rsp_t got;
      sched_rsp_t exp;
      got = {acc, fnd, chosen, irq, running};
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: no request outstanding: acc=%b found=%b chosen=%0d irq=%b run=%0d",
                   $realtime, acc, fnd, chosen, irq, running);
      end else begin
        exp = expected_rsp.pop_front();
        if (got !== exp) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: mismatch, expected acc=%b found=%b chosen=%0d irq=%b run=%0d",
                     $realtime, exp.accepted, exp.found, exp.chosen_index,
                     exp.interrupt_launched, exp.running_index);
            $display("%0t:           actual   acc=%b found=%b chosen=%0d irq=%b run=%0d",
                     $realtime, acc, fnd, chosen, irq, running);
          end
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [psch_pkg::CFG_ADDR_W-1:0] cfg_index;
  logic [psch_pkg::CFG_DATA_W-1:0] cfg_data;

  psch_req_if req_ch();
  psch_rsp_if rsp_ch();

  task_table_model sched_table;
  bit              steady;
  bit              stall_rsp;
  int              quiet_cycles;

  periodic_priority_task_scheduler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // response side: random back-pressure plus one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      if (stall_rsp) begin
        stall_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= 36);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sched_table.check_response(rsp_ch.accepted, rsp_ch.found, rsp_ch.chosen_index,
                                 rsp_ch.interrupt_launched, rsp_ch.running_index);
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(input logic [psch_pkg::FUNC_W-1:0] func,
                              input logic [psch_pkg::PERIOD_W-1:0] period,
                              input logic [psch_pkg::PRIO_W-1:0] prio,
                              input logic [psch_pkg::FIELD_IDX_W-1:0] idx);
    while (!steady && $urandom_range(99) < 36) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= func;
    req_ch.period_in   <= period;
    req_ch.priority_in <= prio;
    req_ch.index_in    <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sched_table.note_request(func, period, prio, idx);
  endtask

  // lets every outstanding request come back, then lets the design settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sched_table.expected_rsp.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [psch_pkg::TICK_W-1:0] interval,
                                input logic [psch_pkg::FIELD_IDX_W-1:0] int_task,
                                input logic [psch_pkg::FIELD_IDX_W-1:0] sched_task);
    cfg_we    <= 1'b1;
    cfg_index <= psch_pkg::CFG_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= psch_pkg::CFG_INT_TASK;
    cfg_data  <= psch_pkg::CFG_DATA_W'(int_task);
    @(posedge clk);
    cfg_index <= psch_pkg::CFG_SCHED_TASK;
    cfg_data  <= psch_pkg::CFG_DATA_W'(sched_task);
    @(posedge clk);
    cfg_we <= 1'b0;
    sched_table.write_reg(psch_pkg::CFG_INTERVAL, interval);
    sched_table.write_reg(psch_pkg::CFG_INT_TASK, psch_pkg::CFG_DATA_W'(int_task));
    sched_table.write_reg(psch_pkg::CFG_SCHED_TASK, psch_pkg::CFG_DATA_W'(sched_task));
  endtask

  task automatic run_phase(input int items);
    logic [psch_pkg::FUNC_W-1:0]      func;
    logic [psch_pkg::PERIOD_W-1:0]    period;
    logic [psch_pkg::PRIO_W-1:0]      prio;
    logic [psch_pkg::FIELD_IDX_W-1:0] idx;
    int                               roll;
    for (int n = 0; n < items; n++) begin
      roll   = $urandom_range(99);
      period = $urandom;
      prio   = psch_pkg::PRIO_W'($urandom);
      idx    = psch_pkg::FIELD_IDX_W'($urandom_range(15));
      if (roll < 8) func = psch_pkg::FUNC_ADD;
      else if (roll < 43) func = psch_pkg::FUNC_TICK;
      else if (roll < 63) func = psch_pkg::FUNC_PICK;
      else if (roll < 83) func = psch_pkg::FUNC_COMPLETE;
      else if (roll < 93) func = psch_pkg::FUNC_YIELD;
      else func = psch_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
      if (func == psch_pkg::FUNC_ADD) begin
        // about half short periods so tasks keep getting released
        case ($urandom_range(9))
          0:       period = '0;
          1, 2, 3: period = $urandom_range(1, 6);
          4, 5:    period = $urandom_range(7, 40);
          6:       period = '1;
          7:       period = $urandom_range(1, 65535);
          default: ;
        endcase
        // narrow band of priorities to force ties
        if ($urandom_range(1)) prio = psch_pkg::PRIO_W'(100 + $urandom_range(1));
      end
      send_request(func, period, prio, idx);
    end
  endtask

  initial begin
    sched_table = new();
    steady       = 1'b0;
    stall_rsp    = 1'b0;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.func        <= '0;
    req_ch.period_in   <= '0;
    req_ch.priority_in <= '0;
    req_ch.index_in    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: nothing to pick, complete or yield to
    send_request(psch_pkg::FUNC_PICK, '0, '0, '0);
    send_request(psch_pkg::FUNC_COMPLETE, '0, '0, 4'd15);
    send_request(psch_pkg::FUNC_COMPLETE, '0, '0, 4'd0);
    send_request(psch_pkg::FUNC_YIELD, '0, '0, '0);
    send_request(psch_pkg::FUNC_TICK, '0, '0, '0);
    send_request(FUNC_UNUSED_FIRST, '1, '1, '1);
    send_request(FUNC_UNUSED_MID, '1, '1, '1);
    send_request(FUNC_UNUSED_LAST, '1, '1, '1);
    drain();
    // interval fires every tick but the interrupt task is not registered
    write_settings(32'd1, 4'd15, 4'd0);
    send_request(psch_pkg::FUNC_TICK, '0, '0, '0);
    send_request(psch_pkg::FUNC_ADD, '0, '0, '0);
    send_request(psch_pkg::FUNC_ADD, '1, '1, '0);
    send_request(psch_pkg::FUNC_ADD, 32'd1, 8'd200, '0);
    send_request(psch_pkg::FUNC_ADD, 32'd1, 8'd200, '0);
    send_request(psch_pkg::FUNC_ADD, 32'd2, 8'h55, '0);
    drain();
    // zero interval: launch check fires on every tick
    write_settings(32'd0, 4'd4, 4'd2);
    send_request(psch_pkg::FUNC_TICK, '0, '0, '0);
    send_request(psch_pkg::FUNC_PICK, '0, '0, '0);
    send_request(psch_pkg::FUNC_PICK, '0, '0, '0);
    send_request(psch_pkg::FUNC_PICK, '0, '0, '0);
    send_request(psch_pkg::FUNC_YIELD, '0, '0, '0);
    send_request(psch_pkg::FUNC_COMPLETE, '0, '0, 4'd2);
    send_request(psch_pkg::FUNC_COMPLETE, '0, '0, 4'd15);
    send_request(psch_pkg::FUNC_TICK, '0, '0, '0);
    drain();

    write_settings(psch_pkg::INTERVAL_RESET, 4'd1, 4'd0);
    stall_rsp = 1'b1;
    run_phase(PHASE_ITEMS);
    drain();

    write_settings(32'd3, 4'd0, 4'd15);
    steady = 1'b1;
    run_phase(PHASE_ITEMS);
    drain();
    steady = 1'b0;

    write_settings('1, 4'd15, 4'd7);
    run_phase(PHASE_ITEMS);
    drain();

    write_settings(32'd0, psch_pkg::FIELD_IDX_W'($urandom_range(15)),
                   psch_pkg::FIELD_IDX_W'($urandom_range(15)));
    run_phase(PHASE_ITEMS);
    drain();

    write_settings($urandom_range(1, 8), psch_pkg::FIELD_IDX_W'($urandom_range(15)),
                   psch_pkg::FIELD_IDX_W'($urandom_range(15)));
    run_phase(PHASE_ITEMS);
    drain();

    if (sched_table.errors == 0 && sched_table.expected_rsp.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
